FILE: rtl/ppc_pkg.sv
// Package for the PID position controller: widths, scaling constants,
// register indexes and the gain set type. No dependencies.
package ppc_pkg;

   // Encoder sample width used for scaling (8..16)
   localparam int SAMPLE_BITS = 12;
   localparam int RAW_W       = 12;   // width of the raw_position field
   localparam int RAW_EXT_W   = 16;   // raw reading widened to the largest sample width
   localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
   localparam int TRAVEL_Q8   = 512000;

   localparam int POS_W   = 19;                    // microns, 8 fraction bits
   localparam int NUM_W   = SAMPLE_BITS + POS_W;   // scaled numerator
   localparam int FOLD_STEPS = (NUM_W + SAMPLE_BITS - 1) / SAMPLE_BITS;   // residue folds
   localparam int CNT_W   = $clog2(FOLD_STEPS + 1);

   localparam int ERR_W   = 21;
   localparam int DERIV_W = 22;
   localparam int SUM_W   = 40;
   localparam int SUM_LO_W = 20;                    // low slice of the integral
   localparam int GAIN_W  = 16;
   localparam int MUL_A_W = GAIN_W + 1;             // gain as a signed operand
   localparam int MUL_B_W = DERIV_W;                // widest signed operand
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 58;
   localparam int FRAC_W  = 16;                     // fraction bits of the product sum
   localparam int DRIVE_W = 12;
   localparam logic [DRIVE_W-1:0] DRIVE_MAX = '1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd128;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gain_set_type;

endpackage

FILE: rtl/ppc_channels.sv
// Request and response channel interfaces for the PID position controller.
// Depends on ppc_pkg for field widths.
interface ppc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ppc_pkg::RAW_W-1:0]   raw_position;
   logic [ppc_pkg::POS_W-1:0]   target_position;

   modport source (output valid, output raw_position, output target_position, input ready);
   modport sink   (input valid, input raw_position, input target_position, output ready);
endinterface

interface ppc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ppc_pkg::DRIVE_W-1:0] drive_value;
   logic [ppc_pkg::POS_W-1:0]   measured_position;

   modport source (output valid, output drive_value, output measured_position, input ready);
   modport sink   (input valid, input drive_value, input measured_position, output ready);
endinterface

FILE: rtl/ppc_scaler.sv
// Encoder scaling: raw * 512000 / full scale, rounded. The full scale is
// 2^SAMPLE_BITS - 1, so the residue is folded one digit per cycle, then
// corrected once. Depends on ppc_pkg.
module ppc_scaler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ppc_pkg::RAW_W-1:0]       raw_position,
   output logic                            done,
   output logic [ppc_pkg::POS_W-1:0]       position
);

   logic [ppc_pkg::RAW_EXT_W-1:0]   raw_ext;
   logic [ppc_pkg::NUM_W-1:0]       numer;
   logic [ppc_pkg::POS_W-1:0]       fold_hi;
   logic [ppc_pkg::SAMPLE_BITS-1:0] fold_lo;
   logic [ppc_pkg::NUM_W-1:0]       rest_ff, rest_in;
   logic [ppc_pkg::POS_W-1:0]       quo_ff, quo_in;
   logic [ppc_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   // Rounded numerator; the reading is masked to the sample width
   assign raw_ext = ppc_pkg::RAW_EXT_W'(raw_position);
   assign numer   = ppc_pkg::NUM_W'(raw_ext[ppc_pkg::SAMPLE_BITS-1:0])
                    * ppc_pkg::NUM_W'(ppc_pkg::TRAVEL_Q8)
                    + ppc_pkg::NUM_W'(ppc_pkg::FULL_SCALE / 2);

   // hi * 2^S + lo = hi * full scale + (hi + lo)
   assign fold_hi = rest_ff[ppc_pkg::NUM_W-1:ppc_pkg::SAMPLE_BITS];
   assign fold_lo = rest_ff[ppc_pkg::SAMPLE_BITS-1:0];

   always_comb begin
      rest_in = rest_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rest_in = numer;
         quo_in  = '0;
         cnt_in  = ppc_pkg::CNT_W'(ppc_pkg::FOLD_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            quo_in  = quo_ff + fold_hi;
            rest_in = ppc_pkg::NUM_W'(fold_hi) + ppc_pkg::NUM_W'(fold_lo);
            cnt_in  = cnt_ff - 1'b1;
         end else begin
            // residue is now at most the full scale
            if (rest_ff >= ppc_pkg::NUM_W'(ppc_pkg::FULL_SCALE)) begin
               quo_in = quo_ff + ppc_pkg::POS_W'(1);
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rest_ff <= rest_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign position = quo_ff;

endmodule

FILE: rtl/ppc_mac.sv
// Shared multiply-accumulate unit: forms kp*e + kd*d + ki*i with one
// 17x22 multiplier over four passes, product registered. Depends on ppc_pkg.
module ppc_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  ppc_pkg::gain_set_type               gains,
   input  logic signed [ppc_pkg::ERR_W-1:0]    error,
   input  logic signed [ppc_pkg::SUM_W-1:0]    integral,
   input  logic signed [ppc_pkg::DERIV_W-1:0]  deriv,
   output logic                                done,
   output logic signed [ppc_pkg::ACC_W-1:0]    acc
);

   typedef enum logic [2:0] {
      STEP_P, STEP_D, STEP_I_LO, STEP_I_HI, STEP_DRAIN
   } mac_step_type;

   mac_step_type                        step_ff, step_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                pvalid_ff, pvalid_in;
   logic                                pshift_ff, pshift_in;
   logic signed [ppc_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ppc_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ppc_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [ppc_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [ppc_pkg::ACC_W-1:0]    addend;

   // Operand select per pass; the integral is split into two 20-bit slices
   always_comb begin
      unique case (step_ff)
         STEP_P: begin
            mul_a = signed'({1'b0, gains.kp});
            mul_b = ppc_pkg::MUL_B_W'(error);
         end
         STEP_D: begin
            mul_a = signed'({1'b0, gains.kd});
            mul_b = deriv;
         end
         STEP_I_LO: begin
            mul_a = signed'({1'b0, gains.ki});
            mul_b = signed'(ppc_pkg::MUL_B_W'(integral[ppc_pkg::SUM_LO_W-1:0]));
         end
         STEP_I_HI: begin
            // high slice carries the sign
            mul_a = signed'({1'b0, gains.ki});
            mul_b = ppc_pkg::MUL_B_W'(signed'(integral[ppc_pkg::SUM_W-1:ppc_pkg::SUM_LO_W]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sign-extend the previous product, shift the high slice into place
   assign addend = pshift_ff ? (ppc_pkg::ACC_W'(prod_ff) <<< ppc_pkg::SUM_LO_W)
                             : ppc_pkg::ACC_W'(prod_ff);

   always_comb begin
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      pvalid_in = 1'b0;
      pshift_in = 1'b0;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      if (start) begin
         step_in = STEP_P;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (pvalid_ff) begin
            acc_in = acc_ff + addend;
         end
         if (step_ff == STEP_DRAIN) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            prod_in   = mul_a * mul_b;
            pvalid_in = 1'b1;
            pshift_in = (step_ff == STEP_I_HI);
            step_in   = mac_step_type'(step_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_P;
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         pvalid_ff <= 1'b0;
         pshift_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         pvalid_ff <= pvalid_in;
         pshift_ff <= pshift_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

FILE: rtl/pid_position_controller_unit.sv
// PID position controller top level: from request accept to response valid a
// request passes 3 fold steps and a correction in the scaler, the error update,
// the multiplier start, the multiplier passes and the output load. The next
// request is taken once the response has moved into the output register, where
// a finished response waits without holding off the next request.
// Synchronous active-high reset: gains to defaults, integral and last error to 0.
module pid_position_controller_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   ppc_req_if.sink                               req_chan,
   ppc_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [ppc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_CALC, ST_MAC, ST_HOLD
   } state_type;

   state_type                              state_ff;
   ppc_pkg::gain_set_type                  gains_ff;
   logic [ppc_pkg::POS_W-1:0]              target_ff;
   logic [ppc_pkg::POS_W-1:0]              pos_ff;
   logic signed [ppc_pkg::ERR_W-1:0]       err_ff, err_in;
   logic signed [ppc_pkg::ERR_W-1:0]       prev_err_ff;
   logic signed [ppc_pkg::SUM_W-1:0]       error_sum_ff, sum_in;
   logic signed [ppc_pkg::DERIV_W-1:0]     deriv_ff, deriv_in;
   logic                                   rsp_valid_ff;
   logic [ppc_pkg::DRIVE_W-1:0]            drive_ff, drive_in;
   logic [ppc_pkg::POS_W-1:0]              meas_ff;

   logic                                   req_fire;
   logic                                   slot_free;
   logic                                   rsp_load;
   logic                                   scl_done;
   logic [ppc_pkg::POS_W-1:0]              scl_pos;
   logic                                   mac_start;
   logic                                   mac_done;
   logic signed [ppc_pkg::ACC_W-1:0]       mac_acc;
   logic signed [ppc_pkg::SUM_W:0]         sum_wide;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign mac_start      = (state_ff == ST_CALC);
   // a finished response moves into the output register
   assign rsp_load       = slot_free
                           && ((state_ff == ST_MAC && mac_done) || state_ff == ST_HOLD);

   ppc_scaler u_scaler (
      .clock        (clock),
      .reset        (reset),
      .start        (req_fire),
      .raw_position (req_chan.raw_position),
      .done         (scl_done),
      .position     (scl_pos)
   );

   ppc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .start    (mac_start),
      .gains    (gains_ff),
      .error    (err_ff),
      .integral (error_sum_ff),
      .deriv    (deriv_ff),
      .done     (mac_done),
      .acc      (mac_acc)
   );

   // Error, saturating integral and derivative
   assign err_in   = signed'({2'b00, target_ff}) - signed'({2'b00, scl_pos});
   assign sum_wide = {error_sum_ff[ppc_pkg::SUM_W-1], error_sum_ff}
                     + (ppc_pkg::SUM_W+1)'(err_in);
   always_comb begin
      if (sum_wide[ppc_pkg::SUM_W] != sum_wide[ppc_pkg::SUM_W-1]) begin
         sum_in = {sum_wide[ppc_pkg::SUM_W], {(ppc_pkg::SUM_W-1){!sum_wide[ppc_pkg::SUM_W]}}};
      end else begin
         sum_in = sum_wide[ppc_pkg::SUM_W-1:0];
      end
   end
   assign deriv_in = {err_in[ppc_pkg::ERR_W-1], err_in}
                     - {prev_err_ff[ppc_pkg::ERR_W-1], prev_err_ff};

   // Output: drop fraction bits, clamp to 0..4095
   always_comb begin
      if (mac_acc[ppc_pkg::ACC_W-1]) begin
         drive_in = '0;
      end else if (|mac_acc[ppc_pkg::ACC_W-2:ppc_pkg::FRAC_W+ppc_pkg::DRIVE_W]) begin
         drive_in = ppc_pkg::DRIVE_MAX;
      end else begin
         drive_in = mac_acc[ppc_pkg::FRAC_W+ppc_pkg::DRIVE_W-1:ppc_pkg::FRAC_W];
      end
   end

   // Gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp <= ppc_pkg::GAIN_P_RESET;
         gains_ff.ki <= '0;
         gains_ff.kd <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ppc_pkg::CSR_GAIN_P: gains_ff.kp <= csr_write_data;
            ppc_pkg::CSR_GAIN_I: gains_ff.ki <= csr_write_data;
            ppc_pkg::CSR_GAIN_D: gains_ff.kd <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequencer, loop state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  target_ff <= req_chan.target_position;
                  state_ff  <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (scl_done) begin
                  pos_ff       <= scl_pos;
                  err_ff       <= err_in;
                  error_sum_ff <= sum_in;
                  deriv_ff     <= deriv_in;
                  prev_err_ff  <= err_in;
                  state_ff     <= ST_CALC;
               end
            end
            ST_CALC: begin
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (mac_done) begin
                  if (slot_free) begin
                     drive_ff <= drive_in;
                     meas_ff  <= pos_ff;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               // accumulator holds its value until the next start
               if (slot_free) begin
                  drive_ff <= drive_in;
                  meas_ff  <= pos_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.drive_value       = drive_ff;
   assign rsp_chan.measured_position = meas_ff;

   // One request in flight at a time
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request accepted while another is in flight");

   // Unit completions line up with the sequencer
   a_scaler_done: assert property (@(posedge clock) disable iff (reset)
      scl_done |-> state_ff == ST_SCALE)
      else $error("scaler finished outside the scaling phase");

   a_mac_done: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_MAC)
      else $error("multiply-accumulate finished outside its phase");

   // Loop state changes only on the error update
   a_sum_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(error_sum_ff)) |-> $past(state_ff == ST_SCALE && scl_done))
      else $error("integral changed outside the error update");

endmodule
